/* hw/rtl/affine_trs_decompose_defines.svh */
// Assertion helpers for the affine TRS decomposition block.
`ifndef AFFINE_TRS_DECOMPOSE_DEFINES_SVH
`define AFFINE_TRS_DECOMPOSE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define ATD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("atd assertion failed");

// Next-cycle implication, disabled while in reset.
`define ATD_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("atd assertion failed");

`endif

/* hw/rtl/atd_pkg.sv */
package atd_pkg;

  // 64-bit radicand, one root bit per stage
  localparam int unsigned SQRT_STAGES = 32;
  // one integer bit plus 30 fraction bits, one per stage
  localparam int unsigned DIV_STAGES  = 31;

  localparam logic signed [31:0] ONE30     = 32'sh4000_0000;
  localparam logic        [30:0] ONE30_U   = 31'h4000_0000;
  localparam logic        [30:0] SCALE_MAX = 31'h7FFF_FFFF;

  localparam int unsigned THR_W = 17;

endpackage

/* hw/rtl/atd_in_if.sv */
interface atd_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] col0_x;
  logic signed [31:0] col0_y;
  logic signed [31:0] col0_z;
  logic signed [31:0] col1_x;
  logic signed [31:0] col1_y;
  logic signed [31:0] col1_z;
  logic signed [31:0] col2_x;
  logic signed [31:0] col2_y;
  logic signed [31:0] col2_z;
  logic signed [31:0] trans_x;
  logic signed [31:0] trans_y;
  logic signed [31:0] trans_z;

  modport source (
    output valid, col0_x, col0_y, col0_z, col1_x, col1_y, col1_z,
           col2_x, col2_y, col2_z, trans_x, trans_y, trans_z,
    input  ready
  );
  modport sink (
    input  valid, col0_x, col0_y, col0_z, col1_x, col1_y, col1_z,
           col2_x, col2_y, col2_z, trans_x, trans_y, trans_z,
    output ready
  );
endinterface

/* hw/rtl/atd_out_if.sv */
interface atd_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_trans_x;
  logic signed [31:0] out_trans_y;
  logic signed [31:0] out_trans_z;
  logic        [30:0] scale_x;
  logic        [30:0] scale_y;
  logic        [30:0] scale_z;
  logic signed [31:0] quat_w;
  logic signed [31:0] quat_x;
  logic signed [31:0] quat_y;
  logic signed [31:0] quat_z;

  modport source (
    output valid, out_trans_x, out_trans_y, out_trans_z, scale_x, scale_y, scale_z,
           quat_w, quat_x, quat_y, quat_z,
    input  ready
  );
  modport sink (
    input  valid, out_trans_x, out_trans_y, out_trans_z, scale_x, scale_y, scale_z,
           quat_w, quat_x, quat_y, quat_z,
    output ready
  );
endinterface

/* hw/rtl/affine_trs_decompose.sv */
// Throughput: one request per cycle unless a result waits at the output; two
// 32-stage square roots and two 31-stage dividers in a single pipeline set the depth.
// The whole pipeline advances together; it holds only while a result waits.
// Reset (rst_ni low, async) clears all valid bits and the scale threshold.
module affine_trs_decompose (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [atd_pkg::THR_W-1:0]  cfg_wdata_i,
  atd_in_if.sink                     in_i,
  atd_out_if.source                  out_o
);

  // payload bundles carried alongside the arithmetic
  typedef struct packed {
    logic [8:0][31:0] mag;
    logic [8:0]       neg;
    logic [2:0][31:0] trans;
  } col_pl_t;

  typedef struct packed {
    logic [2:0][30:0] scale;
    logic [2:0][31:0] trans;
  } base_pl_t;

  typedef struct packed {
    logic [8:0] neg;
    logic [2:0] nrm;
    base_pl_t   base;
  } rot_pl_t;

  typedef struct packed {
    logic [3:0][30:0] vmag;
    logic [3:0]       vneg;
    base_pl_t         base;
  } q_pl_t;

  typedef struct packed {
    logic [3:0] vneg;
    logic       nzero;
    base_pl_t   base;
  } fin_pl_t;

  // Global advance: every stage moves unless the output holds a result
  // that has not been taken.
  logic adv;
  logic o_vld_q;
  assign adv      = !o_vld_q || out_o.ready;
  assign in_i.ready = adv;

  // scale threshold register
  logic [atd_pkg::THR_W-1:0] thr_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // flat view of the basis: index = column * 3 + component
  logic signed [31:0] in_c [9];
  assign in_c[0] = in_i.col0_x;
  assign in_c[1] = in_i.col0_y;
  assign in_c[2] = in_i.col0_z;
  assign in_c[3] = in_i.col1_x;
  assign in_c[4] = in_i.col1_y;
  assign in_c[5] = in_i.col1_z;
  assign in_c[6] = in_i.col2_x;
  assign in_c[7] = in_i.col2_y;
  assign in_c[8] = in_i.col2_z;

  // ---------------------------------------------------------------
  // Stage A: magnitudes and signs
  // ---------------------------------------------------------------
  logic    a_vld_q, b_vld_q, c_vld_q;
  col_pl_t a_pl_q, b_pl_q, c_pl_q;
  logic [63:0] b_sq_q [9];
  logic [63:0] c_sum_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
    end else if (adv) begin
      a_vld_q <= in_i.valid;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 9; k++) begin
        a_pl_q.mag[k] <= in_c[k][31] ? (~in_c[k] + 32'd1) : in_c[k];
        a_pl_q.neg[k] <= in_c[k][31];
      end
      a_pl_q.trans[0] <= in_i.trans_x;
      a_pl_q.trans[1] <= in_i.trans_y;
      a_pl_q.trans[2] <= in_i.trans_z;
      // Stage B: squares of the component magnitudes
      for (int k = 0; k < 9; k++) begin
        b_sq_q[k] <= a_pl_q.mag[k] * a_pl_q.mag[k];
      end
      b_pl_q <= a_pl_q;
      // Stage C: squared column lengths
      for (int j = 0; j < 3; j++) begin
        c_sum_q[j] <= b_sq_q[3*j] + b_sq_q[3*j+1] + b_sq_q[3*j+2];
      end
      c_pl_q <= b_pl_q;
    end
  end

  // ---------------------------------------------------------------
  // Column lengths
  // ---------------------------------------------------------------
  logic [31:0] s1_root [3];
  logic        s1_vld;
  col_pl_t     s1_pl;

  for (genvar j = 0; j < 3; j++) begin : g_col_sqrt
    atd_isqrt u_sqrt (
      .clk_i  (clk_i),
      .en_i   (adv),
      .rad_i  (c_sum_q[j]),
      .root_o (s1_root[j])
    );
  end

  atd_delay #(
    .W     ($bits(col_pl_t)),
    .DEPTH (atd_pkg::SQRT_STAGES)
  ) u_dly_col (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (c_vld_q),
    .data_i (c_pl_q),
    .vld_o  (s1_vld),
    .data_o (s1_pl)
  );

  // ---------------------------------------------------------------
  // Stage D: saturate scale, decide which columns get normalized
  // ---------------------------------------------------------------
  logic        d_vld_q;
  col_pl_t     d_pl_q;
  logic [30:0] d_scale_q [3];
  logic [2:0]  d_nrm_q;
  logic [30:0] d_scale_d [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      d_scale_d[j] = s1_root[j][31] ? atd_pkg::SCALE_MAX : s1_root[j][30:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_vld_q <= 1'b0;
    end else if (adv) begin
      d_vld_q <= s1_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d_pl_q <= s1_pl;
      for (int j = 0; j < 3; j++) begin
        d_scale_q[j] <= d_scale_d[j];
        // strictly above threshold; this also rules out a zero divisor
        d_nrm_q[j]   <= d_scale_d[j] > 31'(thr_q);
      end
    end
  end

  // ---------------------------------------------------------------
  // Column normalization: nine dividers, one per matrix entry
  // ---------------------------------------------------------------
  logic [30:0] q1 [9];
  logic        s2_vld;
  rot_pl_t     s2_in, s2_pl;

  for (genvar k = 0; k < 9; k++) begin : g_col_div
    atd_div u_div (
      .clk_i (clk_i),
      .en_i  (adv),
      .num_i (d_pl_q.mag[k]),
      .den_i ({1'b0, d_scale_q[k/3]}),
      .quo_o (q1[k])
    );
  end

  always_comb begin
    s2_in.neg        = d_pl_q.neg;
    s2_in.nrm        = d_nrm_q;
    s2_in.base.trans = d_pl_q.trans;
    for (int j = 0; j < 3; j++) begin
      s2_in.base.scale[j] = d_scale_q[j];
    end
  end

  atd_delay #(
    .W     ($bits(rot_pl_t)),
    .DEPTH (atd_pkg::DIV_STAGES)
  ) u_dly_rot (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (d_vld_q),
    .data_i (s2_in),
    .vld_o  (s2_vld),
    .data_o (s2_pl)
  );

  // ---------------------------------------------------------------
  // Stage E: rotation matrix, row i column j
  // ---------------------------------------------------------------
  logic               e_vld_q;
  base_pl_t           e_pl_q;
  logic signed [31:0] e_r_q [3][3];

  for (genvar i = 0; i < 3; i++) begin : g_row
    for (genvar j = 0; j < 3; j++) begin : g_colm
      logic signed [31:0] qs;
      assign qs = $signed({1'b0, q1[j*3+i]});
      always_ff @(posedge clk_i) begin
        if (adv) begin
          if (s2_pl.nrm[j]) begin
            e_r_q[i][j] <= s2_pl.neg[j*3+i] ? -qs : qs;
          end else begin
            // small column: identity column
            e_r_q[i][j] <= (i == j) ? atd_pkg::ONE30 : '0;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------
  // Stage F: trace, cross sums and differences, diagonal order
  // Stage G: branch select, quarter magnitude
  // Stage H: squares, Stage I: squared norm
  // ---------------------------------------------------------------
  logic f_vld_q, g_vld_q, h_vld_q, i_vld_q;
  base_pl_t f_pl_q;
  logic signed [33:0] f_tr_q, f_d21_q, f_d02_q, f_d10_q;
  logic signed [33:0] f_s01_q, f_s02_q, f_s12_q;
  logic signed [33:0] f_p0_q, f_p1_q, f_p2_q;
  logic               f_c0_q, f_c1_q;

  q_pl_t       g_pl_q, h_pl_q, i_pl_q;
  logic [61:0] h_sq_q [4];
  logic [63:0] i_sum_q;

  logic signed [34:0] g_v   [4];
  logic        [34:0] g_abs [4];
  logic signed [34:0] one35;
  assign one35 = 35'(atd_pkg::ONE30);

  always_comb begin
    if (!f_tr_q[33] && (f_tr_q != '0)) begin
      g_v[0] = one35 + 35'(f_tr_q);
      g_v[1] = 35'(f_d21_q);
      g_v[2] = 35'(f_d02_q);
      g_v[3] = 35'(f_d10_q);
    end else if (f_c0_q) begin
      g_v[0] = 35'(f_d21_q);
      g_v[1] = one35 + 35'(f_p0_q);
      g_v[2] = 35'(f_s01_q);
      g_v[3] = 35'(f_s02_q);
    end else if (f_c1_q) begin
      g_v[0] = 35'(f_d02_q);
      g_v[1] = 35'(f_s01_q);
      g_v[2] = one35 + 35'(f_p1_q);
      g_v[3] = 35'(f_s12_q);
    end else begin
      g_v[0] = 35'(f_d10_q);
      g_v[1] = 35'(f_s02_q);
      g_v[2] = 35'(f_s12_q);
      g_v[3] = one35 + 35'(f_p2_q);
    end
    for (int k = 0; k < 4; k++) begin
      g_abs[k] = g_v[k][34] ? 35'(-g_v[k]) : g_v[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_vld_q <= 1'b0;
      f_vld_q <= 1'b0;
      g_vld_q <= 1'b0;
      h_vld_q <= 1'b0;
      i_vld_q <= 1'b0;
    end else if (adv) begin
      e_vld_q <= s2_vld;
      f_vld_q <= e_vld_q;
      g_vld_q <= f_vld_q;
      h_vld_q <= g_vld_q;
      i_vld_q <= h_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e_pl_q <= s2_pl.base;

      f_pl_q  <= e_pl_q;
      f_tr_q  <= 34'(e_r_q[0][0]) + 34'(e_r_q[1][1]) + 34'(e_r_q[2][2]);
      f_d21_q <= 34'(e_r_q[2][1]) - 34'(e_r_q[1][2]);
      f_d02_q <= 34'(e_r_q[0][2]) - 34'(e_r_q[2][0]);
      f_d10_q <= 34'(e_r_q[1][0]) - 34'(e_r_q[0][1]);
      f_s01_q <= 34'(e_r_q[0][1]) + 34'(e_r_q[1][0]);
      f_s02_q <= 34'(e_r_q[0][2]) + 34'(e_r_q[2][0]);
      f_s12_q <= 34'(e_r_q[1][2]) + 34'(e_r_q[2][1]);
      f_p0_q  <= 34'(e_r_q[0][0]) - 34'(e_r_q[1][1]) - 34'(e_r_q[2][2]);
      f_p1_q  <= 34'(e_r_q[1][1]) - 34'(e_r_q[0][0]) - 34'(e_r_q[2][2]);
      f_p2_q  <= 34'(e_r_q[2][2]) - 34'(e_r_q[0][0]) - 34'(e_r_q[1][1]);
      f_c0_q  <= (e_r_q[0][0] > e_r_q[1][1]) && (e_r_q[0][0] > e_r_q[2][2]);
      f_c1_q  <= e_r_q[1][1] > e_r_q[2][2];

      g_pl_q.base <= f_pl_q;
      for (int k = 0; k < 4; k++) begin
        // magnitude shifted right by two, sign kept apart
        g_pl_q.vmag[k] <= g_abs[k][32:2];
        g_pl_q.vneg[k] <= g_v[k][34];
      end

      h_pl_q <= g_pl_q;
      for (int k = 0; k < 4; k++) begin
        h_sq_q[k] <= g_pl_q.vmag[k] * g_pl_q.vmag[k];
      end

      i_pl_q  <= h_pl_q;
      i_sum_q <= 64'(h_sq_q[0]) + 64'(h_sq_q[1]) + 64'(h_sq_q[2]) + 64'(h_sq_q[3]);
    end
  end

  // ---------------------------------------------------------------
  // Quaternion norm and normalization
  // ---------------------------------------------------------------
  logic [31:0] n_root;
  logic        s3_vld;
  q_pl_t       s3_pl;

  atd_isqrt u_sqrt_q (
    .clk_i  (clk_i),
    .en_i   (adv),
    .rad_i  (i_sum_q),
    .root_o (n_root)
  );

  atd_delay #(
    .W     ($bits(q_pl_t)),
    .DEPTH (atd_pkg::SQRT_STAGES)
  ) u_dly_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (i_vld_q),
    .data_i (i_pl_q),
    .vld_o  (s3_vld),
    .data_o (s3_pl)
  );

  logic [30:0] q2 [4];
  logic        s4_vld;
  fin_pl_t     s4_in, s4_pl;

  for (genvar k = 0; k < 4; k++) begin : g_q_div
    atd_div u_div (
      .clk_i (clk_i),
      .en_i  (adv),
      .num_i ({1'b0, s3_pl.vmag[k]}),
      .den_i (n_root),
      .quo_o (q2[k])
    );
  end

  assign s4_in.vneg  = s3_pl.vneg;
  assign s4_in.nzero = (n_root == '0);
  assign s4_in.base  = s3_pl.base;

  atd_delay #(
    .W     ($bits(fin_pl_t)),
    .DEPTH (atd_pkg::DIV_STAGES)
  ) u_dly_fin (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (s3_vld),
    .data_i (s4_in),
    .vld_o  (s4_vld),
    .data_o (s4_pl)
  );

  // ---------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------
  logic signed [31:0] o_quat_q [4];
  base_pl_t           o_pl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_vld_q <= 1'b0;
    end else if (adv) begin
      o_vld_q <= s4_vld;
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_quat
    logic signed [31:0] qs;
    assign qs = $signed({1'b0, q2[k]});
    always_ff @(posedge clk_i) begin
      if (adv) begin
        if (s4_pl.nzero) begin
          // degenerate vector: identity rotation
          o_quat_q[k] <= (k == 0) ? atd_pkg::ONE30 : '0;
        end else begin
          o_quat_q[k] <= s4_pl.vneg[k] ? -qs : qs;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      o_pl_q <= s4_pl.base;
    end
  end

  assign out_o.valid       = o_vld_q;
  assign out_o.out_trans_x = o_pl_q.trans[0];
  assign out_o.out_trans_y = o_pl_q.trans[1];
  assign out_o.out_trans_z = o_pl_q.trans[2];
  assign out_o.scale_x     = o_pl_q.scale[0];
  assign out_o.scale_y     = o_pl_q.scale[1];
  assign out_o.scale_z     = o_pl_q.scale[2];
  assign out_o.quat_w      = o_quat_q[0];
  assign out_o.quat_x      = o_quat_q[1];
  assign out_o.quat_y      = o_quat_q[2];
  assign out_o.quat_z      = o_quat_q[3];

endmodule

/* hw/rtl/atd_delay.sv */
// Stall-aware delay line: valid bits reset, payload does not.
module atd_delay #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic         vld_i,
  input  logic [W-1:0] data_i,
  output logic         vld_o,
  output logic [W-1:0] data_o
);

  logic         vld_q [DEPTH];
  logic [W-1:0] dat_q [DEPTH];

  for (genvar k = 0; k < DEPTH; k++) begin : g_tap
    logic         vld_in;
    logic [W-1:0] dat_in;
    if (k == 0) begin : g_first
      assign vld_in = vld_i;
      assign dat_in = data_i;
    end else begin : g_next
      assign vld_in = vld_q[k-1];
      assign dat_in = dat_q[k-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dat_q[k] <= dat_in;
      end
    end
  end

  assign vld_o  = vld_q[DEPTH-1];
  assign data_o = dat_q[DEPTH-1];

endmodule

/* hw/rtl/atd_isqrt.sv */
// Pipelined integer square root, one root bit per stage.
module atd_isqrt (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] rad_i,
  output logic [31:0] root_o
);

  localparam int unsigned N = atd_pkg::SQRT_STAGES;

  logic [63:0] rad_q  [N];
  logic [33:0] rem_q  [N];
  logic [31:0] root_q [N];

  for (genvar k = 0; k < N; k++) begin : g_st
    logic [63:0] rad_in;
    logic [33:0] rem_in;
    logic [31:0] root_in;
    logic [35:0] cur;
    logic [35:0] trial;

    if (k == 0) begin : g_first
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    assign cur   = {rem_in, rad_in[63:62]};
    assign trial = {2'b00, root_in, 2'b01};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k] <= {rad_in[61:0], 2'b00};
        if (cur >= trial) begin
          rem_q[k]  <= 34'(cur - trial);
          root_q[k] <= {root_in[30:0], 1'b1};
        end else begin
          rem_q[k]  <= cur[33:0];
          root_q[k] <= {root_in[30:0], 1'b0};
        end
      end
    end
  end

  assign root_o = root_q[N-1];

endmodule

/* hw/rtl/atd_div.sv */
// Pipelined num * 2^30 / den, one quotient bit per stage, clamped to 2^30.
module atd_div (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] num_i,
  input  logic [31:0] den_i,
  output logic [30:0] quo_o
);

  localparam int unsigned N = atd_pkg::DIV_STAGES;

  logic [31:0] rem_q [N];
  logic [30:0] quo_q [N];
  logic [31:0] den_q [N];
  logic        sat_q [N];

  // integer bit: quotient >= 2 saturates at once
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_q[0] <= den_i;
      sat_q[0] <= {1'b0, num_i} >= {den_i, 1'b0};
      if (num_i >= den_i) begin
        rem_q[0] <= num_i - den_i;
        quo_q[0] <= 31'd1;
      end else begin
        rem_q[0] <= num_i;
        quo_q[0] <= 31'd0;
      end
    end
  end

  for (genvar k = 1; k < N; k++) begin : g_st
    logic [32:0] cur;
    assign cur = {rem_q[k-1], 1'b0};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[k] <= den_q[k-1];
        sat_q[k] <= sat_q[k-1];
        if (cur >= {1'b0, den_q[k-1]}) begin
          rem_q[k] <= 32'(cur - {1'b0, den_q[k-1]});
          quo_q[k] <= {quo_q[k-1][29:0], 1'b1};
        end else begin
          rem_q[k] <= cur[31:0];
          quo_q[k] <= {quo_q[k-1][29:0], 1'b0};
        end
      end
    end
  end

  assign quo_o = (sat_q[N-1] || (quo_q[N-1] > atd_pkg::ONE30_U)) ?
                 atd_pkg::ONE30_U : quo_q[N-1];

endmodule

/* hw/rtl/atd_checker.sv */
`include "affine_trs_decompose_defines.svh"

module atd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  atd_in_if.sink    in_i,
  atd_out_if.source out_o
);

  // nothing pending at the output: the pipeline must take requests
  `ATD_ASSERT_IMP(a_idle_ready, clk_i, rst_ni, !out_o.valid, in_i.ready)

  // output ready this cycle: the pipeline advances and takes requests
  `ATD_ASSERT_IMP(a_drain_ready, clk_i, rst_ni, out_o.ready, in_i.ready)

  // a refused result stays put
  `ATD_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_o.valid && !out_o.ready, out_o.valid && $stable(out_o.quat_w) && $stable(out_o.scale_x))

  // quaternion components w and x never exceed one in magnitude
  `ATD_ASSERT_IMP(a_quat_range, clk_i, rst_ni, out_o.valid, (out_o.quat_w <= atd_pkg::ONE30) && (out_o.quat_w >= -atd_pkg::ONE30) && (out_o.quat_x <= atd_pkg::ONE30) && (out_o.quat_x >= -atd_pkg::ONE30))

endmodule

bind affine_trs_decompose atd_checker u_atd_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .in_i   (in_i),
  .out_o  (out_o)
);
